@@ rtl/core/spdr_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and helpers of the speech phaser, echo and reverb chain
package spdr_pkg;

	// sample format and fixed store geometry
	localparam int SW            = 24;
	localparam int PHASER_STAGES = 6;
	localparam int ECHO_AW       = 15;
	localparam int ECHO_DEPTH    = 2 ** ECHO_AW;
	localparam int COMB_AW       = 11;
	localparam int COMB_RAM_AW   = COMB_AW + 2;
	localparam int COMB_RAM_DEPTH = 2 ** COMB_RAM_AW;
	localparam int AP_AW         = 10;
	localparam int AP_RAM_AW     = AP_AW + 1;
	localparam int AP_RAM_DEPTH  = 2 ** AP_RAM_AW;
	localparam int AP_LEN_A      = 556;
	localparam int AP_LEN_B      = 441;
	localparam int K_W = $clog2(PHASER_STAGES > 4 ? PHASER_STAGES : 4);

	// gains Q0.16, amounts Q1.16
	localparam int AMT_W      = 17;
	localparam int AMT_ONE    = 65536;
	localparam int AMT_TWO    = 131072;
	localparam int AMT_THRESH = 65;
	localparam int G_FB_CAP   = 60293;
	localparam int G_DRY_ECHO = 26214;
	localparam int G_LP       = 39322;
	localparam int G_COMB     = 57672;
	localparam int G_AP       = 32768;
	localparam int DLEN_W     = 16;

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 17;

	typedef enum logic [CFG_IW-1:0] {
		REG_PHASER_AMT = 3'd0,
		REG_FEEDBACK_AMT = 3'd1,
		REG_REVERB_AMT = 3'd2,
		REG_DELAY_LEN = 3'd3,
		REG_COMB_LEN0 = 3'd4,
		REG_COMB_LEN1 = 3'd5,
		REG_COMB_LEN2 = 3'd6,
		REG_COMB_LEN3 = 3'd7
	} cfg_reg_t;

	// shared multiply-accumulate unit
	localparam int MA_W  = 25;
	localparam int MB_W  = 19;
	localparam int ACC_W = MA_W + MB_W;
	localparam int SUM_W = ACC_W + 2;

	typedef enum logic [1:0] {
		SH_15,
		SH_16,
		SH_17
	} shift_t;

	typedef struct packed {
		logic                    valid;
		logic                    clr;
		logic signed [MA_W-1:0]  a;
		logic signed [MB_W-1:0]  b;
	} mac_issue_t;

	typedef struct packed {
		logic signed [MA_W-1:0]  c;
		logic                    sub;
		shift_t                  sh;
	} mac_fin_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PH_Y,
		ST_PH_M,
		ST_PH_MIX,
		ST_E_DRY,
		ST_E_WR,
		ST_E_MIX,
		ST_R_LP,
		ST_R_COMB,
		ST_R_AP,
		ST_R_APW,
		ST_R_MIX,
		ST_DONE
	} state_t;

	// saturate a wide signed value to a sample
	function automatic logic signed [SW-1:0] sat24(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(2 ** (SW - 1) - 1);
		lo = -SUM_W'(2 ** (SW - 1));
		if (v > hi) begin
			sat24 = {1'b0, {(SW - 1){1'b1}}};
		end else if (v < lo) begin
			sat24 = {1'b1, {(SW - 1){1'b0}}};
		end else begin
			sat24 = v[SW-1:0];
		end
	endfunction

endpackage

@@ rtl/core/spdr_ram.sv @@
`timescale 1ns / 1ps
// generic single write port memory with registered read
module spdr_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/spdr_mac.sv @@
`timescale 1ns / 1ps
// shared multiply-accumulate unit with rounding shift, offset and saturation
module spdr_mac (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spdr_pkg::mac_issue_t           issue,
	input  spdr_pkg::mac_fin_t             fin,
	output logic signed [spdr_pkg::SW-1:0] result
);
	import spdr_pkg::*;

	logic                     valid_s1;
	logic                     clr_s1;
	logic signed [ACC_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [SUM_W-1:0]  sum;

	// multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= issue.a * issue.b;
		clr_s1  <= issue.clr;
		if (valid_s1) begin
			acc_q <= clr_s1 ? prod_s1 : acc_q + prod_s1;
		end
	end

	// round half up, then offset and saturate
	always_comb begin
		unique case (fin.sh)
			SH_15:   rnd = (acc_q + ACC_W'(1 << 14)) >>> 15;
			SH_16:   rnd = (acc_q + ACC_W'(1 << 15)) >>> 16;
			SH_17:   rnd = (acc_q + ACC_W'(1 << 16)) >>> 17;
			default: rnd = acc_q;
		endcase
		if (fin.sub) begin
			sum = SUM_W'(fin.c) - SUM_W'(rnd);
		end else begin
			sum = SUM_W'(fin.c) + SUM_W'(rnd);
		end
		result = sat24(sum);
	end

endmodule

@@ rtl/core/speech_phaser_delay_reverb_chain.sv @@
`timescale 1ns / 1ps
// top level: phaser, feedback echo and reverb around one shared mac unit
//
//   channel   direction  handshake            payload
//   in        into       in_valid / in_stall   sample_in, phaser_coef
//   out       out of     out_valid / out_stall sample_out
//   cfg       into       cfg_we                cfg_index, cfg_data
//
// every mac operation on the shared unit runs through issue, multiply,
// accumulate and finish; an item runs 13 operations for the phaser, 3 for
// the echo and 10 for the reverb, each effect only when enabled.
// after reset a clearing pass zeroes the delay memories; in_stall is high
// during it and while an item is being worked on.
// a finished beat waits in the output register while the next beat is taken.
module speech_phaser_delay_reverb_chain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [spdr_pkg::SW-1:0]      sample_in,
	input  logic signed [15:0]                  phaser_coef,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [spdr_pkg::SW-1:0]      sample_out,
	input  logic                                cfg_we,
	input  logic [spdr_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [spdr_pkg::CFG_DW-1:0]         cfg_data
);
	import spdr_pkg::*;

	// configuration
	logic [AMT_W-1:0]   phaser_amount_q;
	logic [AMT_W-1:0]   feedback_amount_q;
	logic [AMT_W-1:0]   reverb_amount_q;
	logic [DLEN_W-1:0]  delay_length_q;
	logic [COMB_AW-1:0] comb_len_q [4];

	// sequencer
	state_t           state_q;
	state_t           state_d;
	logic [1:0]       ph_q;
	logic [K_W-1:0]   k_q;
	logic [ECHO_AW-1:0] clr_cnt_q;
	logic             clearing;
	logic             accept;
	logic             fin_op;
	logic             out_free;
	logic             ph_last;

	// model state
	logic signed [SW-1:0] ph_mem_q [PHASER_STAGES];
	logic [ECHO_AW-1:0]   echo_idx_q;
	logic signed [SW-1:0] hold_q;
	logic signed [SW-1:0] lp_q;
	logic [COMB_AW-1:0]   comb_idx_q [4];
	logic [AP_AW-1:0]     ap_idx_q [2];

	// working values
	logic signed [SW-1:0]  s_q;
	logic signed [SW-1:0]  x_q;
	logic signed [SW-1:0]  y_q;
	logic signed [15:0]    g_q;
	logic signed [SW-1:0]  wet_q;
	logic signed [SW-1:0]  d_q;
	logic signed [SW-1:0]  ap_q;
	logic [AMT_W-1:0]      dry_q;
	logic signed [SW+1:0]  sum_q;
	logic signed [SW-1:0]  out_q;
	logic                  out_valid_q;

	// clamped amounts and derived gains
	logic [AMT_W-1:0]    pa, fa, ra;
	logic                pa_on, fa_on, ra_on;
	logic [AMT_W+1:0]    fa3;
	logic [15:0]         fbg;
	logic [DLEN_W-1:0]   echo_len;
	logic [DLEN_W-1:0]   echo_inc;
	logic [ECHO_AW-1:0]  echo_next;
	logic [COMB_AW-1:0]  comb_len;
	logic [COMB_AW:0]    comb_inc;
	logic [COMB_AW-1:0]  comb_next;
	logic [AP_AW:0]      ap_inc;
	logic [AP_AW:0]      ap_len;
	logic [AP_AW-1:0]    ap_next;
	logic signed [SW+1:0] sum_next;
	logic signed [SW+1:0] sum_rnd;
	logic signed [SW-1:0] ap_from_sum;

	// shared unit and memories
	mac_issue_t           issue;
	mac_fin_t             fin;
	logic signed [SW-1:0] mac_res;
	logic                 echo_we, comb_we, ap_we;
	logic [ECHO_AW-1:0]   echo_waddr;
	logic [COMB_RAM_AW-1:0] comb_waddr, comb_raddr;
	logic [AP_RAM_AW-1:0] ap_waddr, ap_raddr;
	logic [SW-1:0]        ram_wdata;
	logic [SW-1:0]        echo_rdata, comb_rdata, ap_rdata;

	assign clearing = (state_q == ST_CLEAR);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign ph_last  = (ph_q == 2'd3);
	assign fin_op   = ph_last && !clearing && (state_q != ST_IDLE) && (state_q != ST_DONE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	// amount clamps and stage enables
	always_comb begin
		pa = (phaser_amount_q > AMT_W'(AMT_ONE)) ? AMT_W'(AMT_ONE) : phaser_amount_q;
		fa = (feedback_amount_q > AMT_W'(AMT_ONE)) ? AMT_W'(AMT_ONE) : feedback_amount_q;
		ra = (reverb_amount_q > AMT_W'(AMT_ONE)) ? AMT_W'(AMT_ONE) : reverb_amount_q;
		pa_on = pa > AMT_W'(AMT_THRESH);
		fa_on = fa > AMT_W'(AMT_THRESH);
		ra_on = ra > AMT_W'(AMT_THRESH);
		fa3 = (AMT_W + 2)'(fa) + (AMT_W + 2)'({fa, 1'b0});
		fbg = ((fa3 >> 2) > (AMT_W + 2)'(G_FB_CAP)) ? 16'(G_FB_CAP) : fa3[17:2];
	end

	// index wrap logic and comb sum rounding
	always_comb begin
		if (delay_length_q == '0) begin
			echo_len = DLEN_W'(1);
		end else if (delay_length_q > DLEN_W'(ECHO_DEPTH)) begin
			echo_len = DLEN_W'(ECHO_DEPTH);
		end else begin
			echo_len = delay_length_q;
		end
		echo_inc  = DLEN_W'(echo_idx_q) + DLEN_W'(1);
		echo_next = (echo_inc >= echo_len) ? '0 : echo_inc[ECHO_AW-1:0];

		comb_len  = (comb_len_q[k_q[1:0]] == '0) ? COMB_AW'(1) : comb_len_q[k_q[1:0]];
		comb_inc  = (COMB_AW + 1)'(comb_idx_q[k_q[1:0]]) + (COMB_AW + 1)'(1);
		comb_next = (comb_inc >= (COMB_AW + 1)'(comb_len)) ? '0 : comb_inc[COMB_AW-1:0];

		ap_len  = k_q[0] ? (AP_AW + 1)'(AP_LEN_B) : (AP_AW + 1)'(AP_LEN_A);
		ap_inc  = (AP_AW + 1)'(ap_idx_q[k_q[0]]) + (AP_AW + 1)'(1);
		ap_next = (ap_inc >= ap_len) ? '0 : ap_inc[AP_AW-1:0];

		sum_next    = sum_q + (SW + 2)'(d_q);
		sum_rnd     = (sum_next + (SW + 2)'(2)) >>> 2;
		ap_from_sum = sat24(SUM_W'(sum_rnd));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					priority if (pa_on) state_d = ST_PH_Y;
					else if (fa_on)     state_d = ST_E_DRY;
					else if (ra_on)     state_d = ST_R_LP;
					else                state_d = ST_DONE;
				end
			end
			ST_PH_Y: begin
				if (ph_last) state_d = ST_PH_M;
			end
			ST_PH_M: begin
				if (ph_last) begin
					state_d = (k_q == K_W'(PHASER_STAGES - 1)) ? ST_PH_MIX : ST_PH_Y;
				end
			end
			ST_PH_MIX: begin
				if (ph_last) begin
					priority if (fa_on) state_d = ST_E_DRY;
					else if (ra_on)     state_d = ST_R_LP;
					else                state_d = ST_DONE;
				end
			end
			ST_E_DRY: begin
				if (ph_last) state_d = ST_E_WR;
			end
			ST_E_WR: begin
				if (ph_last) state_d = ST_E_MIX;
			end
			ST_E_MIX: begin
				if (ph_last) state_d = ra_on ? ST_R_LP : ST_DONE;
			end
			ST_R_LP: begin
				if (ph_last) state_d = ST_R_COMB;
			end
			ST_R_COMB: begin
				if (ph_last) state_d = (k_q == K_W'(3)) ? ST_R_AP : ST_R_COMB;
			end
			ST_R_AP: begin
				if (ph_last) state_d = ST_R_APW;
			end
			ST_R_APW: begin
				if (ph_last) state_d = (k_q == K_W'(1)) ? ST_R_MIX : ST_R_AP;
			end
			ST_R_MIX: begin
				if (ph_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand selection for the shared unit and memory controls
	always_comb begin
		issue     = '0;
		fin       = '0;
		fin.sh    = SH_16;
		echo_we   = clearing;
		comb_we   = clearing && ({1'b0, clr_cnt_q} < (ECHO_AW + 1)'(COMB_RAM_DEPTH));
		ap_we     = clearing && ({1'b0, clr_cnt_q} < (ECHO_AW + 1)'(AP_RAM_DEPTH));
		echo_waddr = clearing ? clr_cnt_q : echo_idx_q;
		comb_waddr = clearing ? clr_cnt_q[COMB_RAM_AW-1:0]
		                      : {k_q[1:0], comb_idx_q[k_q[1:0]]};
		ap_waddr   = clearing ? clr_cnt_q[AP_RAM_AW-1:0] : {k_q[0], ap_idx_q[k_q[0]]};
		comb_raddr = {k_q[1:0], comb_idx_q[k_q[1:0]]};
		ap_raddr   = {k_q[0], ap_idx_q[k_q[0]]};
		ram_wdata  = clearing ? '0 : mac_res;
		unique case (state_q)
			ST_PH_Y: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(x_q), b: MB_W'(g_q)};
				fin.c = MA_W'(ph_mem_q[k_q]);
				fin.sub = 1'b1;
				fin.sh = SH_15;
			end
			ST_PH_M: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(y_q), b: MB_W'(g_q)};
				fin.c = MA_W'(x_q);
				fin.sh = SH_15;
			end
			ST_PH_MIX: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(x_q), b: MB_W'(pa)};
				fin.c = MA_W'(s_q);
			end
			ST_E_DRY: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(fa), b: MB_W'(G_DRY_ECHO)};
				fin.c = MA_W'(AMT_ONE);
				fin.sub = 1'b1;
			end
			ST_E_WR: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(hold_q), b: MB_W'(fbg)};
				fin.c = MA_W'(s_q);
				echo_we = ph_last;
			end
			ST_E_MIX: begin
				if (ph_q == 2'd0) begin
					issue = '{valid: 1'b1, clr: 1'b1, a: MA_W'(s_q), b: MB_W'(dry_q)};
				end else if (ph_q == 2'd1) begin
					issue = '{valid: 1'b1, clr: 1'b0, a: MA_W'(wet_q), b: MB_W'(fa)};
				end
			end
			ST_R_LP: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1,
				          a: MA_W'(s_q) - MA_W'(lp_q), b: MB_W'(G_LP)};
				fin.c = MA_W'(lp_q);
			end
			ST_R_COMB: begin
				issue = '{valid: ph_q == 2'd1, clr: 1'b1,
				          a: MA_W'($signed(comb_rdata)), b: MB_W'(G_COMB)};
				fin.c = MA_W'(lp_q);
				comb_we = ph_last;
			end
			ST_R_AP: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(ap_q), b: MB_W'(G_AP)};
				fin.c = MA_W'(d_q);
				fin.sub = 1'b1;
			end
			ST_R_APW: begin
				issue = '{valid: ph_q == 2'd0, clr: 1'b1, a: MA_W'(y_q), b: MB_W'(G_AP)};
				fin.c = MA_W'(ap_q);
				ap_we = ph_last;
			end
			ST_R_MIX: begin
				if (ph_q == 2'd0) begin
					issue = '{valid: 1'b1, clr: 1'b1, a: MA_W'(s_q), b: MB_W'(AMT_TWO - ra)};
				end else if (ph_q == 2'd1) begin
					issue = '{valid: 1'b1, clr: 1'b0, a: MA_W'(ap_q), b: MB_W'({ra, 1'b0})};
				end
				fin.sh = SH_17;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phaser_amount_q   <= '0;
			feedback_amount_q <= '0;
			reverb_amount_q   <= '0;
			delay_length_q    <= DLEN_W'(18000);
			comb_len_q[0]     <= COMB_AW'(1557);
			comb_len_q[1]     <= COMB_AW'(1617);
			comb_len_q[2]     <= COMB_AW'(1491);
			comb_len_q[3]     <= COMB_AW'(1422);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PHASER_AMT:   phaser_amount_q   <= cfg_data;
				REG_FEEDBACK_AMT: feedback_amount_q <= cfg_data;
				REG_REVERB_AMT:   reverb_amount_q   <= cfg_data;
				REG_DELAY_LEN:    delay_length_q    <= cfg_data[DLEN_W-1:0];
				REG_COMB_LEN0:    comb_len_q[0]     <= cfg_data[COMB_AW-1:0];
				REG_COMB_LEN1:    comb_len_q[1]     <= cfg_data[COMB_AW-1:0];
				REG_COMB_LEN2:    comb_len_q[2]     <= cfg_data[COMB_AW-1:0];
				REG_COMB_LEN3:    comb_len_q[3]     <= cfg_data[COMB_AW-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and effect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ph_q        <= '0;
			k_q         <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			echo_idx_q  <= '0;
			hold_q      <= '0;
			lp_q        <= '0;
			for (int i = 0; i < PHASER_STAGES; i++) ph_mem_q[i] <= '0;
			for (int i = 0; i < 4; i++) comb_idx_q[i] <= '0;
			for (int i = 0; i < 2; i++) ap_idx_q[i] <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= (fin_op || clearing || state_q == ST_IDLE || state_q == ST_DONE)
			           ? 2'd0 : ph_q + 2'd1;
			if (clearing) clr_cnt_q <= clr_cnt_q + ECHO_AW'(1);
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) k_q <= '0;
			if (fin_op) begin
				unique case (state_q)
					ST_PH_M: begin
						ph_mem_q[k_q] <= mac_res;
						k_q <= (k_q == K_W'(PHASER_STAGES - 1)) ? '0 : k_q + K_W'(1);
					end
					ST_E_WR: begin
						hold_q     <= wet_q;
						echo_idx_q <= echo_next;
					end
					ST_R_LP: lp_q <= mac_res;
					ST_R_COMB: begin
						comb_idx_q[k_q[1:0]] <= comb_next;
						k_q <= (k_q == K_W'(3)) ? '0 : k_q + K_W'(1);
					end
					ST_R_APW: begin
						ap_idx_q[k_q[0]] <= ap_next;
						k_q <= (k_q == K_W'(1)) ? '0 : k_q + K_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= sample_in;
			x_q <= sample_in;
			g_q <= phaser_coef;
		end
		if (state_q == ST_DONE && out_free) out_q <= s_q;
		if (ph_q == 2'd1) begin
			if (state_q == ST_E_DRY)  wet_q <= $signed(echo_rdata);
			if (state_q == ST_R_COMB) d_q   <= $signed(comb_rdata);
			if (state_q == ST_R_AP)   d_q   <= $signed(ap_rdata);
		end
		if (fin_op) begin
			unique case (state_q)
				ST_PH_Y:   y_q <= mac_res;
				ST_PH_M:   x_q <= y_q;
				ST_PH_MIX: s_q <= mac_res;
				ST_E_DRY:  dry_q <= mac_res[AMT_W-1:0];
				ST_E_MIX:  s_q <= mac_res;
				ST_R_LP:   sum_q <= '0;
				ST_R_COMB: begin
					sum_q <= sum_next;
					if (k_q == K_W'(3)) ap_q <= ap_from_sum;
				end
				ST_R_AP:   y_q <= mac_res;
				ST_R_APW:  ap_q <= y_q;
				ST_R_MIX:  s_q <= mac_res;
				default: begin
				end
			endcase
		end
	end

	spdr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.fin    (fin),
		.result (mac_res)
	);

	spdr_ram #(.W(SW), .DEPTH(ECHO_DEPTH)) u_echo_ram (
		.clk   (clk),
		.we    (echo_we),
		.waddr (echo_waddr),
		.wdata (ram_wdata),
		.raddr (echo_idx_q),
		.rdata (echo_rdata)
	);

	spdr_ram #(.W(SW), .DEPTH(COMB_RAM_DEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (comb_we),
		.waddr (comb_waddr),
		.wdata (ram_wdata),
		.raddr (comb_raddr),
		.rdata (comb_rdata)
	);

	spdr_ram #(.W(SW), .DEPTH(AP_RAM_DEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (ap_we),
		.waddr (ap_waddr),
		.wdata (ram_wdata),
		.raddr (ap_raddr),
		.rdata (ap_rdata)
	);

	// an accepted beat always leaves the idle state
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted beat did not start work");

	// a new result is only loaded from the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output raised outside done state");

	// phaser stage index stays within the stage count
	a_phaser_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PH_Y || state_q == ST_PH_M) |-> k_q < K_W'(PHASER_STAGES))
		else $error("phaser stage index out of range");

	// input stays stalled and no operation finishes while the clearing pass runs
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall && !fin_op)
		else $error("work during clearing pass");

endmodule
